FILE: rtl/core/ubrd_pkg.sv
package ubrd_pkg;

    localparam logic [31:0] DEFAULT_SEED = 32'h9e3779b9;
    localparam logic [31:0] MIX_A = 32'h7feb352d;
    localparam logic [31:0] MIX_B = 32'h846ca68b;

    typedef enum logic [1:0] {
        OP_SEED  = 2'd0,
        OP_BOUND = 2'd1,
        OP_BYTES = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_SEED  = 2'd0,
        CMD_BOUND = 2'd1,
        CMD_BYTES = 2'd2,
        CMD_ZERO  = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [31:0] arg;
        logic [6:0]  count;
    } t_cmd;

    function automatic logic [31:0] xs_step(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

FILE: rtl/core/ubrd_front.sv
module ubrd_front #(
    parameter int MAX_BYTES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_operation,
    input  logic [31:0]      i_seed_value,
    input  logic [31:0]      i_upper_bound,
    input  logic [6:0]       i_byte_count,
    output logic             o_cmd_valid,
    input  logic             i_cmd_pop,
    output ubrd_pkg::t_cmd   o_cmd
);

    ubrd_pkg::t_cmd r_q0, r_q1, n_cmd;
    logic [1:0] r_cnt;
    logic push, keep;

    always_comb begin
        n_cmd = '0;
        keep = 1'b1;
        case (i_operation)
            ubrd_pkg::OP_SEED: begin
                n_cmd.kind = ubrd_pkg::CMD_SEED;
                n_cmd.arg = i_seed_value;
            end
            ubrd_pkg::OP_BOUND: begin
                n_cmd.kind = (i_upper_bound <= 32'd1) ? ubrd_pkg::CMD_ZERO
                                                      : ubrd_pkg::CMD_BOUND;
                n_cmd.arg = i_upper_bound;
            end
            ubrd_pkg::OP_BYTES: begin
                n_cmd.kind = ubrd_pkg::CMD_BYTES;
                n_cmd.count = (i_byte_count > 7'(MAX_BYTES)) ? 7'(MAX_BYTES)
                                                             : i_byte_count;
                keep = (i_byte_count != 7'd0);
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_stall = (r_cnt == 2'd2);
    assign push = i_valid && !o_stall && keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
            if (i_cmd_pop) begin
                r_q0 <= (r_cnt == 2'd2) ? r_q1 : n_cmd;
                if (push) r_q1 <= n_cmd;
            end else if (push) begin
                if (r_cnt == 2'd0) r_q0 <= n_cmd;
                else r_q1 <= n_cmd;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue overflow");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop of empty queue");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_cmd_pop) |=> r_cnt == 2'd2) else $error("lost entry");
`endif

endmodule

FILE: rtl/core/ubrd_back.sv
module ubrd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_pop,
    input  ubrd_pkg::t_cmd   i_cmd,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [31:0]      o_value,
    output logic             o_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_RDIV, S_GEN, S_MIX1, S_MIX2, S_MIX3, S_CHK, S_MDIV, S_BYTE, S_OUT
    } t_state;

    t_state r_state;
    logic [31:0] r_gen, r_n, r_lim, r_word, r_rem, r_div;
    logic [5:0]  r_bit;
    logic [6:0]  r_left;
    logic [1:0]  r_have;
    logic        r_bytes, r_valid, r_last;
    logic [31:0] r_value;
    logic [32:0] trial;
    logic [31:0] rem_sh;
    logic        out_load;

    assign rem_sh = {r_rem[30:0], r_div[31]};
    assign trial = {r_rem, r_div[31]} - {1'b0, r_n};
    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_last = r_last;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid && !r_valid;
    assign out_load = (o_cmd_pop && (i_cmd.kind == ubrd_pkg::CMD_ZERO))
                   || ((r_state inside {S_BYTE, S_OUT}) && (!r_valid || !i_stall));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gen <= ubrd_pkg::DEFAULT_SEED;
            r_valid <= 1'b0;
        end else begin
            if (out_load) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_n <= i_cmd.arg;
                        r_left <= i_cmd.count;
                        r_have <= 2'd0;
                        case (i_cmd.kind)
                            ubrd_pkg::CMD_SEED: r_gen <= (i_cmd.arg == 32'd0)
                                ? ubrd_pkg::DEFAULT_SEED : i_cmd.arg;
                            ubrd_pkg::CMD_ZERO: begin
                                r_value <= 32'd0;
                                r_last <= 1'b1;
                            end
                            ubrd_pkg::CMD_BOUND: begin
                                r_bytes <= 1'b0;
                                r_div <= 32'd0 - i_cmd.arg;
                                r_rem <= 32'd0;
                                r_bit <= 6'd32;
                                r_state <= S_RDIV;
                            end
                            default: begin
                                r_bytes <= 1'b1;
                                r_state <= S_GEN;
                            end
                        endcase
                    end
                end
                S_RDIV, S_MDIV: begin
                    if (r_bit == 6'd0) begin
                        if (r_state == S_RDIV) begin
                            r_lim <= 32'd0 - r_rem;
                            r_state <= S_GEN;
                        end else begin
                            r_value <= r_rem;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_div <= {r_div[30:0], 1'b0};
                        r_rem <= trial[32] ? rem_sh : trial[31:0];
                        r_bit <= r_bit - 6'd1;
                    end
                end
                S_GEN: begin
                    r_gen <= ubrd_pkg::xs_step(r_gen);
                    r_word <= ubrd_pkg::xs_step(r_gen);
                    r_state <= S_MIX1;
                end
                S_MIX1: begin
                    r_word <= (r_word ^ (r_word >> 16)) * ubrd_pkg::MIX_A;
                    r_state <= S_MIX2;
                end
                S_MIX2: begin
                    r_word <= (r_word ^ (r_word >> 15)) * ubrd_pkg::MIX_B;
                    r_state <= S_MIX3;
                end
                S_MIX3: begin
                    r_word <= r_word ^ (r_word >> 16);
                    r_state <= r_bytes ? S_BYTE : S_CHK;
                    r_have <= 2'd3;
                end
                S_CHK: begin
                    if (r_lim != 32'd0 && r_word >= r_lim) begin
                        r_state <= S_GEN;
                    end else begin
                        r_div <= r_word;
                        r_rem <= 32'd0;
                        r_bit <= 6'd32;
                        r_state <= S_MDIV;
                    end
                end
                S_BYTE: begin
                    if (!r_valid || !i_stall) begin
                        r_value <= {24'd0, r_word[7:0]};
                        r_last <= (r_left == 7'd1);
                        r_word <= r_word >> 8;
                        r_left <= r_left - 7'd1;
                        r_have <= r_have - 2'd1;
                        if (r_left == 7'd1) r_state <= S_IDLE;
                        else if (r_have == 2'd0) r_state <= S_GEN;
                    end
                end
                S_OUT: begin
                    if (!r_valid || !i_stall) begin
                        r_last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_gen_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_gen != 32'd0)
        else $error("generator state is zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> r_valid && $stable(r_value)) else $error("word lost");
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> r_value < r_n) else $error("remainder out of range");
`endif

endmodule

FILE: rtl/core/unbiased_bounded_random_draw_unit.sv
// Random draw unit: xorshift32 generator with a multiply-xorshift finaliser.
// The input channel (i_valid/o_stall) takes one command word per handshake:
// reseed, a draw below a bound, or a run of random bytes.
// The output channel (o_valid/i_stall) gives result words with o_last on
// the final word of each command; a reseed gives no word.
// A front stage classifies commands into a two-entry queue; a back engine
// runs them, so new commands are taken while results wait.
// A bounded draw runs two bit-serial 32-bit remainder passes, one for the
// rejection limit and one for the result, and generates a new word for each
// rejected one. A bound of 0 or 1 answers zero with no division and no
// generated word. A byte draw generates one word for every four bytes.
// Reset loads the default seed and empties the queue and the output.
// While the receiver stalls, the output word holds and the engine waits
// before its next word; once the queue is full o_stall is raised.
module unbiased_bounded_random_draw_unit #(
    parameter int MAX_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_seed_value,
    input  logic [31:0] i_upper_bound,
    input  logic [6:0]  i_byte_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value,
    output logic        o_last
);

    ubrd_pkg::t_cmd cmd;
    logic cmd_valid, cmd_pop;

    ubrd_front #(.MAX_BYTES(MAX_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_operation, .i_seed_value,
        .i_upper_bound, .i_byte_count,
        .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop), .o_cmd(cmd)
    );

    ubrd_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop),
        .i_cmd(cmd), .o_valid, .i_stall, .o_value, .o_last
    );

endmodule

FILE: tb/tb_unbiased_bounded_random_draw_unit.sv
module tb_unbiased_bounded_random_draw_unit;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        ubrd_pkg::t_op op;
        logic [31:0]   seed;
        logic [31:0]   bound;
        logic [6:0]    count;
        bit            typed;
        logic [31:0]   want_value;
    } t_row;

    typedef struct {
        logic [31:0] value;
        logic        last;
    } t_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_operation;
    logic [31:0] i_seed_value;
    logic [31:0] i_upper_bound;
    logic [6:0]  i_byte_count;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_value;
    logic        o_last;

    unbiased_bounded_random_draw_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_seed_value(i_seed_value),
        .i_upper_bound(i_upper_bound), .i_byte_count(i_byte_count),
        .o_valid(o_valid), .i_stall(i_stall), .o_value(o_value), .o_last(o_last)
    );

    logic [31:0] gen_state;
    t_word       pending_words[$];
    t_row        rows[$];
    int          mismatches;
    int          idle_cycles;
    int          words_seen;
    int          bound_draws;
    int          byte_draws;
    bit          sending_done;
    bit          hold_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] next_word();
        logic [31:0] s;
        logic [31:0] x;
        s = gen_state;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        gen_state = s;
        x = s;
        x = x ^ (x >> 16);
        x = x * 32'h7feb352d;
        x = x ^ (x >> 15);
        x = x * 32'h846ca68b;
        x = x ^ (x >> 16);
        return x;
    endfunction

    task automatic predict_draw(input t_row r);
        logic [31:0] reject;
        logic [31:0] limit;
        logic [31:0] v;
        logic [31:0] w;
        int n;
        t_word e;
        case (r.op)
            ubrd_pkg::OP_SEED: begin
                gen_state = (r.seed == 32'd0) ? ubrd_pkg::DEFAULT_SEED : r.seed;
            end
            ubrd_pkg::OP_BOUND: begin
                if (r.bound <= 32'd1) begin
                    v = 32'd0;
                end else begin
                    reject = (32'd0 - r.bound) % r.bound;
                    if (reject == 32'd0) begin
                        v = next_word() % r.bound;
                    end else begin
                        limit = 32'd0 - reject;
                        do v = next_word(); while (v >= limit);
                        v = v % r.bound;
                    end
                end
                if (r.typed && v !== r.want_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("typed row for bound %0d: expected %h, predicted %h",
                                 r.bound, r.want_value, v);
                end
                e.value = v;
                e.last = 1'b1;
                pending_words.push_back(e);
                bound_draws++;
            end
            ubrd_pkg::OP_BYTES: begin
                n = (r.count > 7'd64) ? 64 : int'(r.count);
                w = 32'd0;
                for (int k = 0; k < n; k++) begin
                    if (k % 4 == 0) w = next_word();
                    e.value = {24'd0, w[7:0]};
                    e.last = (k + 1 == n);
                    pending_words.push_back(e);
                    w = w >> 8;
                end
                if (n > 0) byte_draws++;
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_row make_row(ubrd_pkg::t_op op, logic [31:0] seed,
                                      logic [31:0] bound, logic [6:0] count, bit typed,
                                      logic [31:0] want);
        t_row r;
        r.op = op;
        r.seed = seed;
        r.bound = bound;
        r.count = count;
        r.typed = typed;
        r.want_value = want;
        return r;
    endfunction

    function automatic t_row random_row();
        int pick;
        logic [31:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            return make_row(ubrd_pkg::OP_SEED,
                            ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom(),
                            $urandom(), 7'($urandom()), 1'b0, 32'd0);
        end else if (pick < 60) begin
            case ($urandom_range(0, 4))
                0: b = $urandom_range(0, 16);
                1: b = 32'd1 << $urandom_range(0, 31);
                2: b = 32'h8000_0000 + $urandom_range(0, 32'h7fff_ffff);
                3: b = 32'hffff_ffff - $urandom_range(0, 3);
                default: b = $urandom();
            endcase
            return make_row(ubrd_pkg::OP_BOUND, $urandom(), b, 7'($urandom()), 1'b0,
                            32'd0);
        end else if (pick < 95) begin
            return make_row(ubrd_pkg::OP_BYTES, $urandom(), $urandom(),
                            ($urandom_range(0, 15) == 0) ? 7'($urandom_range(0, 127))
                                                         : 7'($urandom_range(1, 9)),
                            1'b0, 32'd0);
        end
        return make_row(ubrd_pkg::OP_NONE, $urandom(), $urandom(), 7'($urandom()), 1'b0,
                        32'd0);
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = ubrd_pkg::OP_SEED;
        i_seed_value = 32'd0;
        i_upper_bound = 32'd0;
        i_byte_count = 7'd0;
        gen_state = ubrd_pkg::DEFAULT_SEED;
        mismatches = 0;
        sending_done = 1'b0;
        bound_draws = 0;
        byte_draws = 0;

        rows.push_back(make_row(ubrd_pkg::OP_BOUND, 32'd0, 32'd0, 7'd0, 1'b1, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BOUND, 32'd0, 32'd1, 7'd0, 1'b1, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BOUND, 32'd0, 32'd2, 7'd0, 1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BOUND, 32'd0, 32'd3, 7'd0, 1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BOUND, 32'd0, 32'hffff_ffff, 7'd0, 1'b0,
                                32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BOUND, 32'd0, 32'h8000_0000, 7'd0, 1'b0,
                                32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BOUND, 32'd0, 32'h8000_0001, 7'd0, 1'b0,
                                32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BOUND, 32'd0, 32'hc000_0001, 7'd0, 1'b0,
                                32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_SEED, 32'd0, 32'd0, 7'd0, 1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BYTES, 32'd0, 32'd0, 7'd1, 1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BYTES, 32'd0, 32'd0, 7'd0, 1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BYTES, 32'd0, 32'd0, 7'd5, 1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_SEED, 32'hffff_ffff, 32'hffff_ffff, 7'h7f,
                                1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BYTES, 32'd0, 32'd0, 7'd64, 1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BYTES, 32'd0, 32'd0, 7'd65, 1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BYTES, 32'd0, 32'd0, 7'd127, 1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_NONE, 32'hffff_ffff, 32'hffff_ffff, 7'h7f,
                                1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_SEED, 32'd1, 32'd0, 7'd0, 1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BOUND, 32'd0, 32'd7, 7'd0, 1'b0, 32'd0));
        rows.push_back(make_row(ubrd_pkg::OP_BOUND, 32'd0, 32'd1, 7'd0, 1'b1, 32'd0));
        for (int i = 0; i < 250; i++) rows.push_back(random_row());

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        while (rows.size() > 0) begin
            int burst;
            burst = $urandom_range(1, 12);
            while (burst > 0 && rows.size() > 0) begin
                t_row r;
                r = rows.pop_front();
                i_valid <= 1'b1;
                i_operation <= r.op;
                i_seed_value <= r.seed;
                i_upper_bound <= r.bound;
                i_byte_count <= r.count;
                do @(posedge i_clk); while (o_stall);
                predict_draw(r);
                burst--;
            end
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        sending_done = 1'b1;
    end

    initial begin
        int phase;
        i_stall = 1'b0;
        hold_off = 1'b0;
        @(posedge i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1'b1;
        i_stall <= 1'b1;
        repeat (1500) @(posedge i_clk);
        hold_off = 1'b0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if ((phase / 200) % 2 == 1) i_stall <= 1'b0;
            else i_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_word e;
            words_seen++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: value %h last %b", o_value, o_last);
            end else begin
                e = pending_words.pop_front();
                if (o_value !== e.value || o_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b, got %h/%b",
                                 e.value, e.last, o_value, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        idle_cycles = 0;
        words_seen = 0;
        wait (sending_done);
        while (pending_words.size() > 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timed out with %0d words outstanding", pending_words.size());
            $display("unbiased_bounded_random_draw_unit regression: fail");
            $finish;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d bounded draws and %0d byte runs, %0d result words checked",
                 bound_draws, byte_draws, words_seen);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("unbiased_bounded_random_draw_unit regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("unbiased_bounded_random_draw_unit regression: fail");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog expired");
        $display("unbiased_bounded_random_draw_unit regression: fail");
        $finish;
    end

endmodule
